[src/space_time_ma_residual_nll_defines.svh]
// Assertion macros shared by the residual filter RTL.
// Uses the including module's clk and rst_n; no other dependencies.
`ifndef SPACE_TIME_MA_RESIDUAL_NLL_DEFINES_SVH
`define SPACE_TIME_MA_RESIDUAL_NLL_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define STMAR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stmar assertion failed");

// Next-cycle implication, disabled during reset
`define STMAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stmar assertion failed");

`endif

[src/stmar_pkg.sv]
// Shared types, codes and saturating arithmetic for the residual filter.
// No dependencies.
package stmar_pkg;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_COEFF  = 2'd1,
        OP_OBS    = 2'd2,
        OP_START  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_MEAN  = 2'd0,
        CFG_INV   = 2'd1,
        CFG_LOGC  = 2'd2
    } cfg_idx_t;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RUN   = 10'b0000000010,
        S_DRAIN = 10'b0000000100,
        S_RES   = 10'b0000001000,
        S_SQ    = 10'b0000010000,
        S_MLO   = 10'b0000100000,
        S_MHI   = 10'b0001000000,
        S_TERM  = 10'b0010000000,
        S_ACC   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    // Control from the sequencer to the MAC pipeline
    typedef struct packed {
        logic issue;
        logic clear;
    } mac_ctrl_t;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -66'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

[src/space_time_ma_residual_nll.sv]
// Space-time moving-average residual filter with running Gaussian NLL.
// Depends on stmar_pkg, stmar_ram, stmar_mac and the defines header.
//
// Usage: the request channel (in_valid/in_ready) carries loads of spatial
// weights (operation 0), lag coefficients (1), observations (2) and a
// start-of-series command (3). Observations arrive site by site, column by
// column; each gives one result on the out_valid/out_ready channel with its
// residual, site, column and the running negative log-likelihood.
// Loads and start give no result. An observation runs F*ORDERS*SITES MAC terms
// (none, and no NLL term, when F = 0), where F is the number of stored lag
// columns (0..LAGS); no new request is taken until its result is registered.
// The MAC pipeline does one weight/coefficient/residual term per cycle, fed by
// one read per cycle of each memory. With the default parameters a full
// history gives 16*4*4 terms per observation.
// A finished result sits in an output register; the next request is taken
// while it waits. If the receiver still stalls when the following result is
// ready, the block holds in its last step until the register frees.
// Reset (asynchronous, rst_n low) clears the series state and out_valid and loads
// the configuration defaults; weights and coefficients are undefined until loaded. No clearing pass.
// Configuration registers may be written only while the block is idle.
`include "space_time_ma_residual_nll_defines.svh"
module space_time_ma_residual_nll
    import stmar_pkg::*;
#(
    parameter int SITES     = 16,
    parameter int ORDERS    = 4,
    parameter int LAGS      = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [3:0]         row_site,
    input  logic [3:0]         neighbour_site,
    input  logic [1:0]         spatial_order,
    input  logic [1:0]         time_lag,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] residual,
    output logic [3:0]         site,
    output logic [15:0]        column,
    output logic signed [63:0] neg_log_lik,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int SITE_W = (SITES > 1) ? $clog2(SITES) : 1;
    localparam int ORD_W  = (ORDERS > 1) ? $clog2(ORDERS) : 1;
    localparam int LAG_W  = (LAGS > 1) ? $clog2(LAGS) : 1;
    localparam int SLOT_W = $clog2(LAGS + 1);
    localparam int FILL_W = $clog2(LAGS + 1);
    localparam int W_AW   = 2 * SITE_W + ORD_W;
    localparam int C_AW   = ORD_W + LAG_W;
    localparam int H_AW   = SLOT_W + SITE_W;
    localparam int SHIFT2 = 2 * FRAC_BITS;

    // configuration registers
    logic signed [31:0] mean_reg, lnc_reg;
    logic [31:0]        inv_reg;

    // series state
    state_t             state_reg;
    logic [SITE_W-1:0]  k_reg;
    logic [15:0]        col_reg;
    logic [SLOT_W-1:0]  cur_reg;
    logic [FILL_W-1:0]  filled_reg;
    logic signed [63:0] nll_reg;

    // iteration counters
    logic [LAG_W-1:0]   i_reg;
    logic [ORD_W-1:0]   j_reg;
    logic [SITE_W-1:0]  u_reg;
    logic [SLOT_W-1:0]  lag_slot_reg;

    // item datapath
    logic signed [31:0] obs_reg, res_reg, prev_x_reg;
    logic signed [63:0] sq_reg, term_reg;
    logic [63:0]        lo_reg, hi_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] out_res_reg;
    logic [3:0]         out_site_reg;
    logic [15:0]        out_col_reg;
    logic signed [63:0] out_nll_reg;

    logic               accept;
    logic               load_ok_w, load_ok_c;
    logic [W_AW-1:0]    w_waddr, w_raddr;
    logic [C_AW-1:0]    c_waddr, c_raddr;
    logic [H_AW-1:0]    h_waddr, h_raddr;
    logic [31:0]        w_rdata, c_rdata, h_rdata;
    logic               h_we;
    logic [SLOT_W-1:0]  prev_slot;
    logic signed [31:0] res_next;
    logic signed [65:0] diff;
    logic signed [63:0] mac_sum;
    logic               mac_busy;
    mac_ctrl_t          mac_ctrl;
    logic               last_u, last_j, last_i, out_free;
    logic [95:0]        full_prod, q_full;
    logic signed [63:0] sq_term;

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(LAGS) : s - 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(LAGS)) ? '0 : s + 1'b1;
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid & in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign prev_slot = slot_dec(cur_reg);

    // load index checks
    assign load_ok_w = (32'(row_site) < SITES) && (32'(neighbour_site) < SITES)
                       && (32'(spatial_order) < ORDERS);
    assign load_ok_c = (32'(spatial_order) < ORDERS) && (32'(time_lag) < LAGS);

    // memory addressing
    assign w_waddr = {SITE_W'(row_site), SITE_W'(neighbour_site), ORD_W'(spatial_order)};
    assign c_waddr = {ORD_W'(spatial_order), LAG_W'(time_lag)};
    assign w_raddr = {k_reg, u_reg, j_reg};
    assign c_raddr = {j_reg, i_reg};
    assign h_raddr = (state_reg == S_DRAIN) ? {prev_slot, k_reg} : {lag_slot_reg, u_reg};
    assign h_waddr = {cur_reg, k_reg};
    assign h_we    = (state_reg == S_RES);

    stmar_ram #(.WIDTH(32), .DEPTH(2 ** W_AW)) u_weight_ram (
        .clk   (clk),
        .we    (accept && operation == OP_WEIGHT && load_ok_w),
        .waddr (w_waddr),
        .wdata (value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    stmar_ram #(.WIDTH(32), .DEPTH(2 ** C_AW)) u_coeff_ram (
        .clk   (clk),
        .we    (accept && operation == OP_COEFF && load_ok_c),
        .waddr (c_waddr),
        .wdata (value),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    stmar_ram #(.WIDTH(32), .DEPTH(2 ** H_AW)) u_hist_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (res_next),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    assign mac_ctrl.issue = (state_reg == S_RUN);
    assign mac_ctrl.clear = accept && operation == OP_OBS;

    stmar_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .theta  (c_rdata),
        .weight (w_rdata),
        .hist_x (h_rdata),
        .sum    (mac_sum),
        .busy   (mac_busy)
    );

    // residual: observation minus mean minus filter sum, saturated
    assign diff     = 66'(obs_reg) - 66'(mean_reg) - 66'(mac_sum);
    assign res_next = sat32(diff);

    // previous column's residual at this site, squared and scaled by 1/(2 sigma^2), saturated to the 64-bit max
    assign full_prod = {hi_reg, 32'b0} + {32'b0, lo_reg};
    assign q_full    = full_prod >> SHIFT2;
    assign sq_term   = (q_full > 96'(S64_MAX)) ? S64_MAX : q_full[63:0];

    assign last_u = (u_reg == SITE_W'(SITES - 1));
    assign last_j = (j_reg == ORD_W'(ORDERS - 1));
    assign last_i = (FILL_W'(i_reg) + 1'b1 == filled_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            inv_reg  <= 32'd32768;
            lnc_reg  <= 32'sd60223;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MEAN: mean_reg <= cfg_data;
                CFG_INV:  inv_reg  <= cfg_data;
                CFG_LOGC: lnc_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    // sequencer and series state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            col_reg       <= '0;
            cur_reg       <= '0;
            filled_reg    <= '0;
            nll_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            u_reg         <= '0;
            lag_slot_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // result taken; a new one is loaded from S_DONE instead
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (operation == OP_OBS)
                        begin
                            i_reg        <= '0;
                            j_reg        <= '0;
                            u_reg        <= '0;
                            lag_slot_reg <= prev_slot;
                            state_reg    <= (filled_reg != '0) ? S_RUN : S_DRAIN;
                        end
                        else if (operation == OP_START)
                        begin
                            k_reg      <= '0;
                            col_reg    <= '0;
                            cur_reg    <= '0;
                            filled_reg <= '0;
                            nll_reg    <= '0;
                        end
                    end
                end
                S_RUN:
                begin
                    u_reg <= last_u ? '0 : u_reg + 1'b1;
                    if (last_u)
                    begin
                        j_reg <= last_j ? '0 : j_reg + 1'b1;
                        if (last_j)
                        begin
                            i_reg        <= i_reg + 1'b1;
                            lag_slot_reg <= slot_dec(lag_slot_reg);
                            if (last_i)
                            begin
                                state_reg <= S_DRAIN;
                            end
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (!mac_busy)
                    begin
                        state_reg <= S_RES;
                    end
                end
                S_RES:
                begin
                    state_reg <= (filled_reg != '0) ? S_SQ : S_DONE;
                end
                S_SQ:   state_reg <= S_MLO;
                S_MLO:  state_reg <= S_MHI;
                S_MHI:  state_reg <= S_TERM;
                S_TERM: state_reg <= S_ACC;
                S_ACC:
                begin
                    nll_reg   <= sat_add64(nll_reg, term_reg);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (k_reg == SITE_W'(SITES - 1))
                        begin
                            k_reg   <= '0;
                            col_reg <= col_reg + 1'b1;
                            cur_reg <= slot_inc(cur_reg);
                            if (filled_reg != FILL_W'(LAGS))
                            begin
                                filled_reg <= filled_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // item datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_OBS)
        begin
            obs_reg <= value;
        end
        if (state_reg == S_RES)
        begin
            res_reg    <= res_next;
            prev_x_reg <= h_rdata;
        end
        if (state_reg == S_SQ)
        begin
            sq_reg <= prev_x_reg * prev_x_reg;
        end
        if (state_reg == S_MLO)
        begin
            lo_reg <= 64'(sq_reg[31:0]) * 64'(inv_reg);
        end
        if (state_reg == S_MHI)
        begin
            hi_reg <= 64'(sq_reg[63:32]) * 64'(inv_reg);
        end
        if (state_reg == S_TERM)
        begin
            term_reg <= sat_add64(sq_term, 64'(lnc_reg));
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_res_reg  <= res_reg;
            out_site_reg <= 4'(k_reg);
            out_col_reg  <= col_reg;
            out_nll_reg  <= nll_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign residual    = out_res_reg;
    assign site        = out_site_reg;
    assign column      = out_col_reg;
    assign neg_log_lik = out_nll_reg;

    `STMAR_ASSERT_NOW(a_run_needs_history, state_reg == S_RUN, filled_reg != '0)
    `STMAR_ASSERT_NOW(a_res_after_drain, state_reg == S_RES, !mac_busy)
    `STMAR_ASSERT_NOW(a_fill_bound, 1'b1, filled_reg <= FILL_W'(LAGS))
    `STMAR_ASSERT_NEXT(a_done_loads_out, state_reg == S_DONE && out_free, out_valid_reg)

endmodule

[src/stmar_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module stmar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/stmar_mac.sv]
// Three-stage multiply-accumulate: theta*W, then times stored residual, then
// saturating sum. Depends on stmar_pkg.
module stmar_mac
    import stmar_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mac_ctrl_t          ctrl,
    input  logic signed [31:0] theta,
    input  logic signed [31:0] weight,
    input  logic signed [31:0] hist_x,
    output logic signed [63:0] sum,
    output logic               busy
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [63:0] p1_reg, p2_reg, sum_reg;
    logic signed [31:0] x1_reg;
    logic signed [63:0] p1_sh, p2_sh;
    logic signed [31:0] tw;

    assign p1_sh = p1_reg >>> FRAC_BITS;
    assign tw    = sat32({{2{p1_sh[63]}}, p1_sh});
    assign p2_sh = p2_reg >>> FRAC_BITS;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            p1_reg <= theta * weight;
            x1_reg <= hist_x;
        end
        if (v2_reg)
        begin
            p2_reg <= tw * x1_reg;
        end
        if (ctrl.clear)
        begin
            sum_reg <= '0;
        end
        else if (v3_reg)
        begin
            sum_reg <= sat_add64(sum_reg, p2_sh);
        end
    end

    assign sum  = sum_reg;
    assign busy = v1_reg | v2_reg | v3_reg;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for space_time_ma_residual_nll: loads weight and
// coefficient tables, streams series of observations and checks every result.
// Depends on stmar_pkg and the space_time_ma_residual_nll RTL.
module tb_top;
    import stmar_pkg::*;

    localparam int  N_SITES   = 16;
    localparam int  N_ORDERS  = 4;
    localparam int  N_LAGS    = 4;
    localparam int  OBS_TARGET = 1000;
    localparam int  DRAIN_CYCLES = 400;
    localparam int  HOLD_CYCLES  = 2000;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SMIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic signed [31:0] residual;
        logic [3:0]         site;
        logic [15:0]        column;
        logic signed [63:0] nll;
    } obs_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         operation;
    logic [3:0]         row_site;
    logic [3:0]         neighbour_site;
    logic [1:0]         spatial_order;
    logic [1:0]         time_lag;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] residual;
    logic [3:0]         site;
    logic [15:0]        column;
    logic signed [63:0] neg_log_lik;
    logic               cfg_write_en;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    // Predictor state
    logic signed [31:0] weight_mem [N_SITES][N_SITES][N_ORDERS];
    logic signed [31:0] coeff_mem [N_ORDERS][N_LAGS];
    logic signed [31:0] resid_hist [N_LAGS][N_SITES];
    logic signed [31:0] resid_col [N_SITES];
    int                 hist_head;
    int                 cur_site;
    int                 cur_column;
    int                 lags_filled;
    longint             nll_sum;
    longint             mean_reg;
    longint             inv_var_reg;
    longint             log_const_reg;

    obs_result_t        pending_results[$];
    int                 errors;
    int                 obs_sent;
    longint             cycle_cnt;
    bit                 no_idle;
    bit                 hold_req;

    space_time_ma_residual_nll uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .row_site(row_site), .neighbour_site(neighbour_site),
        .spatial_order(spatial_order), .time_lag(time_lag), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .residual(residual), .site(site), .column(column), .neg_log_lik(neg_log_lik),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("** space_time_ma_residual_nll: FAILED **");
            $finish;
        end
    end

    // Saturating 64-bit add
    function automatic longint add_sat(input longint a, input longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? SMIN : SMAX;
        return s[63:0];
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // floor(r^2 * inv / 2^32), clipped to the 64-bit maximum
    function automatic longint nll_term(input logic signed [31:0] r, input longint inv);
        longint       r64;
        logic [127:0] prod;
        r64  = r;
        prod = 128'(r64 * r64) * 128'(inv);
        prod = prod >> 32;
        if (prod > 128'(SMAX))
            return SMAX;
        return longint'(prod[63:0]);
    endfunction

    function automatic void clear_series_state();
        for (int l = 0; l < N_LAGS; l++)
            for (int u = 0; u < N_SITES; u++)
                resid_hist[l][u] = '0;
        for (int u = 0; u < N_SITES; u++)
            resid_col[u] = '0;
        hist_head   = 0;
        cur_site    = 0;
        cur_column  = 0;
        lags_filled = 0;
        nll_sum     = 0;
    endfunction

    // Residual and running NLL for one observation
    function automatic void predict_observation(input logic signed [31:0] obs);
        longint      acc;
        longint      tw;
        longint      res;
        int          slot;
        obs_result_t r;
        acc = 0;
        for (int i = 0; i < lags_filled; i++)
        begin
            slot = (hist_head + N_LAGS - 1 - i) % N_LAGS;
            for (int j = 0; j < N_ORDERS; j++)
                for (int u = 0; u < N_SITES; u++)
                begin
                    tw  = clip32((longint'(coeff_mem[j][i]) *
                                  longint'(weight_mem[cur_site][u][j])) >>> 16);
                    acc = add_sat(acc, (tw * longint'(resid_hist[slot][u])) >>> 16);
                end
        end
        res = longint'(obs) - mean_reg;
        if (acc == SMIN)
            res = SMAX;
        else
            res = add_sat(res, -acc);
        res = clip32(res);
        resid_col[cur_site] = res[31:0];
        if (lags_filled > 0)
        begin
            slot    = (hist_head + N_LAGS - 1) % N_LAGS;
            nll_sum = add_sat(nll_sum, add_sat(nll_term(resid_hist[slot][cur_site],
                                                        inv_var_reg), log_const_reg));
        end
        r.residual = res[31:0];
        r.site     = cur_site[3:0];
        r.column   = cur_column[15:0];
        r.nll      = nll_sum;
        pending_results.push_back(r);
        if (cur_site == N_SITES - 1)
        begin
            for (int u = 0; u < N_SITES; u++)
                resid_hist[hist_head][u] = resid_col[u];
            hist_head = (hist_head + 1) % N_LAGS;
            if (lags_filled < N_LAGS)
                lags_filled++;
            cur_column = (cur_column + 1) & 16'hFFFF;
            cur_site   = 0;
        end
        else
            cur_site++;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    // Send one request; called at a rising edge, returns at the accepting edge
    task automatic send_req(input op_t op, input logic [3:0] row, input logic [3:0] nb,
                            input logic [1:0] ord, input logic [1:0] lag,
                            input logic signed [31:0] val);
        int gap;
        bit rdy;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        operation      <= op;
        row_site       <= row;
        neighbour_site <= nb;
        spatial_order  <= ord;
        time_lag       <= lag;
        value          <= val;
        forever
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
            if (rdy)
                break;
        end
        case (op)
            OP_WEIGHT: weight_mem[row][nb][ord] = val;
            OP_COEFF:  coeff_mem[ord][lag] = val;
            OP_START:  clear_series_state();
            default:
            begin
                predict_observation(val);
                obs_sent++;
            end
        endcase
    endtask

    task automatic send_obs(input logic signed [31:0] val);
        send_req(OP_OBS, 4'($urandom), 4'($urandom), 2'($urandom), 2'($urandom), val);
    endtask

    function automatic logic signed [31:0] rand_obs();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 1048576)) - 524288;
    endfunction

    function automatic logic signed [31:0] rand_weight();
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        return $signed($urandom_range(0, 16384)) - 8192;
    endfunction

    // Wait until the block is idle, then write all three registers
    task automatic write_config(input logic [31:0] mean_v, input logic [31:0] inv_v,
                                input logic [31:0] logc_v);
        in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_MEAN;
        cfg_data     <= mean_v;
        @(posedge clk);
        cfg_index    <= CFG_INV;
        cfg_data     <= inv_v;
        @(posedge clk);
        cfg_index    <= CFG_LOGC;
        cfg_data     <= logc_v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        mean_reg      = longint'($signed(mean_v));
        inv_var_reg   = longint'(inv_v);
        log_const_reg = longint'($signed(logc_v));
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 99) < 20)
            begin
                stall_left = pick_gap();
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Result checker, sampled mid-cycle
    initial
    begin
        obs_result_t exp_r;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no expectation: residual %0d site %0d", residual,
                           site);
                    errors++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (residual !== exp_r.residual)
                    begin
                        $error("residual: expected %0d actual %0d", exp_r.residual, residual);
                        errors++;
                    end
                    if (site !== exp_r.site)
                    begin
                        $error("site: expected %0d actual %0d", exp_r.site, site);
                        errors++;
                    end
                    if (column !== exp_r.column)
                    begin
                        $error("column: expected %0d actual %0d", exp_r.column, column);
                        errors++;
                    end
                    if (neg_log_lik !== exp_r.nll)
                    begin
                        $error("neg_log_lik: expected %0d actual %0d", exp_r.nll,
                               neg_log_lik);
                        errors++;
                    end
                end
            end
        end
    end

    // Fill every weight and coefficient so no observation reads an unwritten entry
    task automatic test_table_load();
        for (int k = 0; k < N_SITES; k++)
            for (int u = 0; u < N_SITES; u++)
                for (int j = 0; j < N_ORDERS; j++)
                    send_req(OP_WEIGHT, k[3:0], u[3:0], j[1:0], 2'($urandom),
                             rand_weight());
        for (int j = 0; j < N_ORDERS; j++)
            for (int i = 0; i < N_LAGS; i++)
                send_req(OP_COEFF, 4'($urandom), 4'($urandom), j[1:0], i[1:0],
                         rand_weight());
    endtask

    // Field extremes and saturating products
    task automatic test_directed();
        logic signed [31:0] keep_w;
        logic signed [31:0] keep_c;
        keep_w = weight_mem[0][15][3];
        keep_c = coeff_mem[3][0];
        send_req(OP_WEIGHT, 4'd0, 4'd15, 2'd3, 2'd3, 32'sh7FFF_FFFF);
        send_req(OP_COEFF, 4'd15, 4'd0, 2'd3, 2'd0, 32'sh8000_0000);
        send_req(OP_START, 4'd15, 4'd15, 2'd3, 2'd3, 32'sh7FFF_FFFF);
        for (int k = 0; k < N_SITES; k++)
            case (k % 4)
                0: send_obs(32'sh7FFF_FFFF);
                1: send_obs(32'sh8000_0000);
                2: send_obs(32'sd0);
                default: send_obs(-32'sd1);
            endcase
        send_obs(32'sh7FFF_FFFF);
        send_obs(32'sh8000_0000);
        send_req(OP_WEIGHT, 4'd0, 4'd15, 2'd3, 2'd0, keep_w);
        send_req(OP_COEFF, 4'd0, 4'd0, 2'd3, 2'd0, keep_c);
    endtask

    // Output held off for a long stretch while observations keep coming
    task automatic test_backpressure();
        send_req(OP_START, 4'd0, 4'd0, 2'd0, 2'd0, 32'sd0);
        hold_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_obs(rand_obs());
    endtask

    // Random series with noise reloads and cut-short series
    task automatic test_random_series();
        int cols;
        int phase;
        phase = 0;
        while (obs_sent < OBS_TARGET)
        begin
            if (obs_sent > (phase + 1) * 250)
            begin
                phase++;
                case (phase % 4)
                    1: write_config(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
                    2: write_config(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
                    3: write_config($urandom, $urandom, $urandom);
                    default: write_config(32'd0, 32'd32768, 32'd60223);
                endcase
            end
            no_idle = ($urandom_range(0, 4) == 0);
            send_req(OP_START, 4'($urandom), 4'($urandom), 2'($urandom), 2'($urandom),
                     $urandom);
            cols = $urandom_range(1, 7);
            for (int c = 0; c < cols * N_SITES; c++)
            begin
                case ($urandom_range(0, 99))
                    0: send_req(OP_WEIGHT, 4'($urandom), 4'($urandom), 2'($urandom),
                                2'($urandom), rand_weight());
                    1: send_req(OP_COEFF, 4'($urandom), 4'($urandom), 2'($urandom),
                                2'($urandom), rand_weight());
                    default: ;
                endcase
                if ($urandom_range(0, 199) == 0)
                    break;
                send_obs(rand_obs());
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        errors         = 0;
        obs_sent       = 0;
        cycle_cnt      = 0;
        no_idle        = 1'b0;
        hold_req       = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = OP_START;
        row_site       = '0;
        neighbour_site = '0;
        spatial_order  = '0;
        time_lag       = '0;
        value          = '0;
        cfg_write_en   = 1'b0;
        cfg_index      = CFG_MEAN;
        cfg_data       = '0;
        mean_reg       = 0;
        inv_var_reg    = 32768;
        log_const_reg  = 60223;
        clear_series_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_directed();
        write_config(32'h0001_8000, 32'h0000_4000, 32'hFFFF_0000);
        test_backpressure();
        test_random_series();

        in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() > 0)
            errors++;
        if (errors == 0)
            $display("** space_time_ma_residual_nll: PASSED **");
        else
            $display("** space_time_ma_residual_nll: FAILED **");
        $finish;
    end

endmodule
